[design/mqtt_fixed_header_framer_unit_macros.svh]
// ---------------------------------------------------------------------------
// mqtt fixed header framer assertion macros
// shared concurrent assertion shorthands, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef MQTT_FIXED_HEADER_FRAMER_UNIT_MACROS_SVH
`define MQTT_FIXED_HEADER_FRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FHF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FHF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FHF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define FHF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[design/mqtt_fhf_pkg.sv]
// ---------------------------------------------------------------------------
// mqtt fixed header framer package
// shared types, codes and the end-of-packet rule check
// ---------------------------------------------------------------------------
package mqtt_fhf_pkg;

   localparam int MAX_LENGTH_BYTES_DEFAULT = 4;
   localparam int LEN_W                    = 28;
   localparam int CFG_W                    = 21;
   localparam logic [CFG_W-1:0] MAX_PACKET_BYTES_RESET = CFG_W'(1024);

   // item commands
   localparam logic CMD_DATA    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // mqtt control packet types
   localparam logic [3:0] PT_CONNACK  = 4'd2;
   localparam logic [3:0] PT_PUBLISH  = 4'd3;
   localparam logic [3:0] PT_PUBACK   = 4'd4;
   localparam logic [3:0] PT_PUBREC   = 4'd5;
   localparam logic [3:0] PT_PUBREL   = 4'd6;
   localparam logic [3:0] PT_PUBCOMP  = 4'd7;
   localparam logic [3:0] PT_SUBACK   = 4'd9;
   localparam logic [3:0] PT_UNSUBACK = 4'd11;
   localparam logic [3:0] PT_PINGRESP = 4'd13;

   localparam logic [3:0] FLAGS_NONE   = 4'h0;
   localparam logic [3:0] FLAGS_PUBREL = 4'h2;
   localparam logic [1:0] QOS_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2,
      PH_ERROR  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_TOO_LARGE = 2'd2
   } status_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic             emit;
      status_type       status;
      logic [3:0]       packet_type;
      logic [3:0]       header_flags;
      logic [LEN_W-1:0] body_length;
   } result_type;

   // client-side type, flag and length rules at packet end
   function automatic status_type check_packet(input logic [3:0]       pkt_type,
                                               input logic [3:0]       flags,
                                               input logic [LEN_W-1:0] len);
      logic       ok;
      logic [1:0] qos;
      qos = flags[2:1];
      case (pkt_type)
         PT_CONNACK, PT_PUBACK, PT_PUBREC, PT_PUBCOMP, PT_UNSUBACK: begin
            ok = (flags == FLAGS_NONE) && (len == LEN_W'(2));
         end
         PT_PUBLISH: begin
            ok = (qos != QOS_RESERVED) &&
                 (len >= ((qos == 2'd0) ? LEN_W'(3) : LEN_W'(5)));
         end
         PT_PUBREL: begin
            ok = (flags == FLAGS_PUBREL) && (len == LEN_W'(2));
         end
         PT_SUBACK: begin
            ok = (flags == FLAGS_NONE) && (len >= LEN_W'(3));
         end
         PT_PINGRESP: begin
            ok = (flags == FLAGS_NONE) && (len == '0);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok ? ST_OK : ST_INVALID;
   endfunction

endpackage

[design/mqtt_fixed_header_framer_unit.sv]
// ---------------------------------------------------------------------------
// mqtt fixed header framer unit
// receive-side fixed header parser: one byte per item, one verdict per packet
// ---------------------------------------------------------------------------
// usage
//  - req channel: one item per byte (req_cmd 0, req_data_byte) or a restart
//    command (req_cmd 1) that returns the parser to the start of a packet
//  - rsp channel: one verdict at packet end, or at once on a length error,
//    with status, type, flags and decoded remaining length
//  - csr channel: write of max_packet_bytes, always ready; write only while idle
//  - an accepted item is held in the input register until it moves on; its
//    verdict is then loaded into the result register, which drives rsp_valid
//  - throughput is one item per cycle unless a verdict stalls; the only loop is
//    the phase/length update, a narrow shift-or plus one 29 bit add and compare
//  - when the receiver stalls a pending verdict the input register holds its
//    item and req_stall rises; nothing is lost or repeated
//  - reset (synchronous) clears both stages, returns the parser to the first
//    header byte and loads max_packet_bytes with 1024
//  - after any error verdict bytes are dropped until a restart command
// ---------------------------------------------------------------------------
`include "mqtt_fixed_header_framer_unit_macros.svh"

module mqtt_fixed_header_framer_unit
   import mqtt_fhf_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   // configuration
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_max_packet_bytes,
   // received bytes
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [7:0]       req_data_byte,
   // verdicts
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_packet_type,
   output logic [3:0]       rsp_header_flags,
   output logic [LEN_W-1:0] rsp_body_length
);

   logic [CFG_W-1:0] max_packet_bytes_ff;
   logic [CFG_W-1:0] max_packet_bytes_in;
   item_type         req_item;
   item_type         item;
   logic             item_valid;
   logic             advance;
   result_type       result;
   result_type       rsp_result;

   // configuration register, always writable
   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_valid && csr_ready) begin
         max_packet_bytes_in = csr_max_packet_bytes;
      end else begin
         max_packet_bytes_in = max_packet_bytes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_packet_bytes_ff <= MAX_PACKET_BYTES_RESET;
      end else begin
         max_packet_bytes_ff <= max_packet_bytes_in;
      end
   end

   assign req_item.cmd       = req_cmd;
   assign req_item.data_byte = req_data_byte;

   // input register
   mqtt_fhf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // parser state steps only when the item moves on
   mqtt_fhf_core #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (item_valid && advance),
      .item             (item),
      .max_packet_bytes (max_packet_bytes_ff),
      .result           (result)
   );

   // result register
   mqtt_fhf_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_status       = rsp_result.status;
   assign rsp_packet_type  = rsp_result.packet_type;
   assign rsp_header_flags = rsp_result.header_flags;
   assign rsp_body_length  = rsp_result.body_length;

   // a stuck verdict must hold back a waiting item
   `FHF_ASSERT_IMP(a_stall_backpressure, clock, reset,
      rsp_valid && rsp_stall && item_valid, req_stall,
      "item advanced past a stalled verdict")

   // status code 3 is never produced
   `FHF_ASSERT_IMP(a_status_legal, clock, reset,
      rsp_valid, rsp_status != 2'd3,
      "illegal status code on rsp channel")

   // an accepted pingresp always has an empty body
   `FHF_ASSERT_IMP(a_pingresp_empty, clock, reset,
      rsp_valid && (rsp_status == ST_OK) && (rsp_packet_type == PT_PINGRESP),
      rsp_body_length == '0,
      "pingresp accepted with nonzero length")

   // a verdict only appears after an item was in the input register
   `FHF_ASSERT_NXT(a_verdict_source, clock, reset,
      !rsp_valid && !item_valid, !rsp_valid,
      "verdict with no item behind it")

endmodule

[design/mqtt_fhf_in_stage.sv]
// ---------------------------------------------------------------------------
// mqtt fhf input stage
// registers one received item and holds it while the result side is blocked
// ---------------------------------------------------------------------------
module mqtt_fhf_in_stage
   import mqtt_fhf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/mqtt_fhf_core.sv]
// ---------------------------------------------------------------------------
// mqtt fhf parse core
// packet phase, length decode and body count, one item per step
// ---------------------------------------------------------------------------
module mqtt_fhf_core
   import mqtt_fhf_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  item_type         item,
   input  logic [CFG_W-1:0] max_packet_bytes,
   output result_type       result
);

   localparam int ACC_W = 7 * MAX_LENGTH_BYTES;
   localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);
   localparam int CMP_W = (ACC_W + 1 > CFG_W) ? ACC_W + 1 : CFG_W;

   phase_type        phase_ff, phase_in;
   logic [7:0]       first_byte_ff, first_byte_in;
   logic [ACC_W-1:0] accum_ff, accum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0] remaining_ff, remaining_in;

   logic [ACC_W-1:0] accum_add;
   logic [ACC_W-1:0] accum_sum;
   logic [CNT_W-1:0] count_inc;
   logic [ACC_W-1:0] remaining_dec;
   logic [CMP_W-1:0] total;
   logic             is_data;
   logic             zero_cont;
   logic             cont;
   logic             too_long;
   logic             too_large;

   // decode of the current byte against the state
   always_comb begin
      accum_add = '0;
      for (int i = 0; i < MAX_LENGTH_BYTES; i++) begin
         if (count_ff == CNT_W'(i)) begin
            accum_add = ACC_W'(item.data_byte[6:0]) << (7 * i);
         end
      end
      accum_sum     = accum_ff | accum_add;
      count_inc     = count_ff + CNT_W'(1);
      is_data       = step_en && (item.cmd == CMD_DATA);
      zero_cont     = (item.data_byte == 8'h00) && (count_ff != '0);
      cont          = item.data_byte[7];
      too_long      = count_inc >= CNT_W'(MAX_LENGTH_BYTES);
      total         = CMP_W'(accum_sum) + CMP_W'(count_inc) + CMP_W'(1);
      too_large     = total > CMP_W'(max_packet_bytes);
      remaining_dec = (remaining_ff != '0) ? remaining_ff - ACC_W'(1) : '0;
   end

   // verdicts
   always_comb begin
      result.emit         = 1'b0;
      result.status       = ST_OK;
      result.packet_type  = first_byte_ff[7:4];
      result.header_flags = first_byte_ff[3:0];
      result.body_length  = '0;
      if (is_data) begin
         case (phase_ff)
            PH_LENGTH: begin
               if (zero_cont || (cont && too_long)) begin
                  result.emit   = 1'b1;
                  result.status = ST_INVALID;
               end else if (!cont && too_large) begin
                  result.emit        = 1'b1;
                  result.status      = ST_TOO_LARGE;
                  result.body_length = LEN_W'(accum_sum);
               end else if (!cont && (accum_sum == '0)) begin
                  result.emit   = 1'b1;
                  result.status = check_packet(first_byte_ff[7:4], first_byte_ff[3:0], '0);
               end
            end
            PH_BODY: begin
               if (remaining_dec == '0) begin
                  result.emit        = 1'b1;
                  result.body_length = LEN_W'(accum_ff);
                  result.status      = check_packet(first_byte_ff[7:4], first_byte_ff[3:0],
                                                    LEN_W'(accum_ff));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in      = phase_ff;
      first_byte_in = first_byte_ff;
      accum_in      = accum_ff;
      count_in      = count_ff;
      remaining_in  = remaining_ff;
      if (step_en && (item.cmd == CMD_RESTART)) begin
         phase_in      = PH_FIRST;
         first_byte_in = '0;
         accum_in      = '0;
         count_in      = '0;
         remaining_in  = '0;
      end else if (is_data) begin
         case (phase_ff)
            PH_FIRST: begin
               first_byte_in = item.data_byte;
               accum_in      = '0;
               count_in      = '0;
               remaining_in  = '0;
               phase_in      = PH_LENGTH;
            end
            PH_LENGTH: begin
               if (!zero_cont) begin
                  accum_in = accum_sum;
                  count_in = count_inc;
                  if (!cont && !too_large && (accum_sum != '0)) begin
                     remaining_in = accum_sum;
                     phase_in     = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               remaining_in = remaining_dec;
            end
            default: begin
            end
         endcase
         if (result.emit) begin
            phase_in = (result.status == ST_OK) ? PH_FIRST : PH_ERROR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         first_byte_ff <= '0;
         accum_ff      <= '0;
         count_ff      <= '0;
         remaining_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         first_byte_ff <= first_byte_in;
         accum_ff      <= accum_in;
         count_ff      <= count_in;
         remaining_ff  <= remaining_in;
      end
   end

endmodule

[design/mqtt_fhf_out_stage.sv]
// ---------------------------------------------------------------------------
// mqtt fhf output stage
// result register, holds a verdict until the receiver takes it
// ---------------------------------------------------------------------------
module mqtt_fhf_out_stage
   import mqtt_fhf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  result_type result,
   input  logic       rsp_stall,
   output logic       advance,
   output logic       rsp_valid,
   output result_type rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       load;

   // slot frees up unless a verdict is stuck
   assign advance = !(valid_ff && rsp_stall);
   assign load    = advance && item_valid && result.emit;

   always_comb begin
      if (advance) begin
         valid_in = load;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
